/* design/ptst_pkg.sv */
// Shared types and constants for the periodic timer slot table.
package ptst_pkg;

    localparam int SLOT_W      = 3;
    localparam int PERIOD_W    = 16;
    localparam int OP_W        = 2;
    localparam int S_DATA_W    = 24;
    localparam int M_DATA_W    = 8;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [OP_W-1:0] {
        OP_REG    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TICK   = 2'd2,
        OP_POLL   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CMD_REGISTER,
        CMD_REMOVE,
        CMD_TICK,
        CMD_POLL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [SLOT_W-1:0]   slot;
        logic [PERIOD_W-1:0] period;
    } cmd_t;

    typedef struct packed {
        logic              last;
        logic              fired;
        logic              full_res;
        logic [SLOT_W-1:0] slot_id;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } back_state_t;

endpackage

/* design/periodic_timer_slot_table.sv */
// A register word passes through the command queue, then the result register, before its answer.
// A poll scans one slot per cycle unless a fire waits on a stalled output, then flushes.
// Remove and tick give no result word; the engine takes no new command during a poll.
// A two-word command queue lets input words be taken while the engine works.
// Reset (aresetn low, synchronous) frees every slot and clears every tick count.
module periodic_timer_slot_table #(
    parameter int SLOTS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ptst_pkg::S_DATA_W-1:0] s_tdata,   // slot[2:0], period[18:3]
    input  logic [ptst_pkg::OP_W-1:0]     s_tuser,   // op[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ptst_pkg::M_DATA_W-1:0] m_tdata,   // slot_id[2:0], full_res[3], fired[4]
    output logic                          m_tlast
);
    import ptst_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    res_t res;
    logic push;
    logic queue_full;
    logic queue_not_empty;
    logic pop;

    ptst_front #(.SLOTS(SLOTS)) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (front_cmd)
    );

    ptst_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (front_cmd),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head_cmd)
    );

    ptst_back #(.SLOTS(SLOTS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (queue_not_empty),
        .cmd       (head_cmd),
        .pop       (pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = M_DATA_W'({res.fired, res.full_res, res.slot_id});
    assign m_tlast = res.last;

endmodule

/* design/ptst_front.sv */
// Front end: accepts input words and turns them into commands for the queue.
module ptst_front #(
    parameter int SLOTS = 8
) (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ptst_pkg::S_DATA_W-1:0] s_tdata,   // slot[2:0], period[18:3]
    input  logic [ptst_pkg::OP_W-1:0]     s_tuser,   // op[1:0]
    input  logic                          queue_full,
    output logic                          push,
    output ptst_pkg::cmd_t                cmd
);
    import ptst_pkg::*;

    logic keep;

    assign s_tready = !queue_full;

    always_comb begin
        cmd.slot   = s_tdata[SLOT_W-1:0];
        cmd.period = s_tdata[SLOT_W+PERIOD_W-1:SLOT_W];
        keep       = 1'b1;
        unique case (op_t'(s_tuser))
            OP_REG:    cmd.kind = CMD_REGISTER;
            OP_REMOVE: begin
                cmd.kind = CMD_REMOVE;
                // A slot number beyond the table is dropped here.
                keep = (32'(cmd.slot) < SLOTS);
            end
            OP_TICK:   cmd.kind = CMD_TICK;
            OP_POLL:   cmd.kind = CMD_POLL;
            default:   cmd.kind = CMD_TICK;
        endcase
    end

    assign push = s_tvalid && !queue_full && keep;

endmodule

/* design/ptst_queue.sv */
// Short command queue between the front end and the slot engine.
module ptst_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ptst_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output ptst_pkg::cmd_t head
);
    import ptst_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* design/ptst_back.sv */
// Slot engine: holds the slot table, executes commands and drives results.
module ptst_back #(
    parameter int SLOTS = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cmd_valid,
    input  ptst_pkg::cmd_t cmd,
    output logic           pop,
    output logic           res_valid,
    input  logic           res_ready,
    output ptst_pkg::res_t res
);
    import ptst_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    back_state_t         state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]   pend_id_reg, pend_id_next;
    logic                out_valid_reg, out_valid_next;
    res_t                out_res_reg, out_res_next;
    logic [SLOTS-1:0]    active_reg, active_next;
    logic [PERIOD_W-1:0] count_reg [SLOTS];
    logic [PERIOD_W-1:0] count_next [SLOTS];
    logic [PERIOD_W-1:0] period_reg [SLOTS];
    logic                period_we;
    logic [IDX_W-1:0]    free_idx;
    logic                free_found;
    logic                out_free;
    logic                hit;

    assign res_valid = out_valid_reg;
    assign res       = out_res_reg;
    assign out_free  = !out_valid_reg || res_ready;

    // Lowest free slot.
    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!active_reg[i]) begin
                free_idx   = IDX_W'(i);
                free_found = 1'b1;
            end
        end
    end

    assign hit = active_reg[idx_reg] && (count_reg[idx_reg] >= period_reg[idx_reg]);

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        out_res_next    = out_res_reg;
        active_next     = active_reg;
        count_next      = count_reg;
        period_we       = 1'b0;
        pop             = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    unique case (cmd.kind)
                        CMD_REGISTER: begin
                            if (out_free) begin
                                pop                   = 1'b1;
                                out_valid_next        = 1'b1;
                                out_res_next.slot_id  = free_found ? SLOT_W'(free_idx) : '0;
                                out_res_next.full_res = !free_found;
                                out_res_next.fired    = 1'b0;
                                out_res_next.last     = 1'b1;
                                if (free_found) begin
                                    active_next[free_idx] = 1'b1;
                                    count_next[free_idx]  = '0;
                                    period_we             = 1'b1;
                                end
                            end
                        end
                        CMD_REMOVE: begin
                            pop = 1'b1;
                            for (int i = 0; i < SLOTS; i++) begin
                                if (int'(cmd.slot) == i) begin
                                    active_next[i] = 1'b0;
                                end
                            end
                        end
                        CMD_TICK: begin
                            pop = 1'b1;
                            for (int i = 0; i < SLOTS; i++) begin
                                count_next[i] = count_reg[i] + 1'b1;
                            end
                        end
                        CMD_POLL: begin
                            pop             = 1'b1;
                            idx_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                // A fire is held back until the next fire or the flush so the final one can carry last.
                if (!(hit && pend_valid_reg && !out_free)) begin
                    if (hit) begin
                        count_next[idx_reg] = '0;
                        pend_valid_next     = 1'b1;
                        pend_id_next        = SLOT_W'(idx_reg);
                        if (pend_valid_reg) begin
                            out_valid_next        = 1'b1;
                            out_res_next.slot_id  = pend_id_reg;
                            out_res_next.full_res = 1'b0;
                            out_res_next.fired    = 1'b1;
                            out_res_next.last     = 1'b0;
                        end
                    end
                    if (idx_reg == IDX_W'(SLOTS - 1)) begin
                        state_next = ST_FLUSH;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    out_valid_next        = 1'b1;
                    out_res_next.slot_id  = pend_valid_reg ? pend_id_reg : '0;
                    out_res_next.full_res = 1'b0;
                    out_res_next.fired    = pend_valid_reg;
                    out_res_next.last     = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            active_reg     <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                count_reg[i] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            active_reg     <= active_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_id_reg <= pend_id_next;
        out_res_reg <= out_res_next;
        if (period_we) begin
            period_reg[free_idx] <= cmd.period;
        end
    end

endmodule

/* design/ptst_checker.sv */
// Port-level checks for the periodic timer slot table, bound to the top level.
module ptst_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ptst_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import ptst_pkg::*;

    // A stalled result word must hold.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // A full answer is always the only word of its item.
    a_full_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tlast && !m_tdata[4])
        else $error("full answer without last or with fired");

    // Only fire words may be followed by more words of the same item.
    a_nonfire_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[4] |-> m_tlast)
        else $error("non-fire word without last");

    // Reset empties the result register.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind periodic_timer_slot_table ptst_checker u_ptst_checker (.*);
